// File: design/fse_pkg.sv
// Shared types, codes and constant tables for the format string expander.
package fse_pkg;

    localparam int ARG_WIDTH_DEF = 32;

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [31:0] arg_value;
    } t_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        is_last;
        logic        done_res;
        logic [15:0] total_count;
        logic [2:0]  error_code;
    } t_res;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_PCT   = 3'd2,
        MODE_OCT2  = 3'd3,
        MODE_OCT3  = 3'd4
    } t_mode;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_ESC  = 3'd1;
    localparam logic [2:0] ERR_OCT2 = 3'd2;
    localparam logic [2:0] ERR_OCT3 = 3'd3;
    localparam logic [2:0] ERR_FMT  = 3'd4;

    typedef enum logic [1:0] {
        RAD_BIN = 2'd0,
        RAD_OCT = 2'd1,
        RAD_HEX = 2'd2,
        RAD_DEC = 2'd3
    } t_radix;

    typedef struct packed {
        logic   load;
        t_radix radix;
        logic   upper;
    } t_conv_cmd;

    typedef struct packed {
        logic       dig_valid;
        logic       dig_last;
        logic [7:0] dig_char;
    } t_conv_stat;

    // fixed text strings, back to back; banner is the tail of the magic text
    localparam int TEXT_LEN = 59;
    localparam logic [5:0] TXT_TAB_START    = 6'd0;
    localparam logic [5:0] TXT_TAB_END      = 6'd5;
    localparam logic [5:0] TXT_FF_START     = 6'd6;
    localparam logic [5:0] TXT_FF_END       = 6'd16;
    localparam logic [5:0] TXT_NL_START     = 6'd17;
    localparam logic [5:0] TXT_NL_END       = 6'd26;
    localparam logic [5:0] TXT_CR_START     = 6'd27;
    localparam logic [5:0] TXT_CR_END       = 6'd35;
    localparam logic [5:0] TXT_MAGIC_START  = 6'd36;
    localparam logic [5:0] TXT_BANNER_START = 6'd49;
    localparam logic [5:0] TXT_BANNER_END   = 6'd58;

    localparam logic [7:0] TEXT_ROM [0:TEXT_LEN-1] = '{
        8'h3C, 8'h74, 8'h61, 8'h62, 8'h3E, 8'h09,
        8'h3C, 8'h66, 8'h6F, 8'h72, 8'h6D, 8'h66, 8'h65, 8'h65, 8'h64, 8'h3E, 8'h0C,
        8'h3C, 8'h6E, 8'h65, 8'h77, 8'h6C, 8'h69, 8'h6E, 8'h65, 8'h3E, 8'h0A,
        8'h3C, 8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h3E, 8'h0D,
        8'h3C, 8'h63, 8'h61, 8'h73, 8'h70, 8'h6C, 8'h20, 8'h6D, 8'h61, 8'h67, 8'h69,
        8'h63, 8'h3E,
        8'h43, 8'h41, 8'h53, 8'h50, 8'h4C, 8'h27, 8'h32, 8'h30, 8'h31, 8'h38
    };

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = 8'h30 + {4'h0, d};
        end else if (upper) begin
            ch = 8'h37 + {4'h0, d};
        end else begin
            ch = 8'h57 + {4'h0, d};
        end
        return ch;
    endfunction

endpackage

// File: design/fse_conv.sv
// Iterative radix converter: shift-add-3 for decimal, then one digit per cycle unless i_take is low.
module fse_conv #(
    parameter int ARG_WIDTH = fse_pkg::ARG_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fse_pkg::t_conv_cmd    i_cmd,
    input  logic [ARG_WIDTH-1:0]  i_value,
    input  logic                  i_take,
    output fse_pkg::t_conv_stat   o_stat
);
    import fse_pkg::*;

    // decimal digits needed for ARG_WIDTH bits
    localparam int ND   = (ARG_WIDTH * 30103) / 100000 + 1;
    localparam int WMAX = (ND * 4 > ARG_WIDTH) ? ND * 4 : ARG_WIDTH;
    // multiple of 12 so the register splits evenly into 1, 3 or 4 bit digits
    localparam int DW   = ((WMAX + 11) / 12) * 12;
    localparam int NNIB = DW / 4;
    localparam int CW   = $clog2(DW + 1);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DAB  = 3'b010,
        C_DIG  = 3'b100
    } t_cstate;

    t_cstate              r_state, n_state;
    logic [DW-1:0]        r_dig, n_dig;
    logic [ARG_WIDTH-1:0] r_bin, n_bin;
    logic [CW-1:0]        r_cnt, n_cnt;
    t_radix               r_radix, n_radix;
    logic                 r_upper, n_upper;
    logic                 r_started, n_started;

    logic [3:0]    top_dig;
    logic [DW-1:0] shifted;
    logic [DW-1:0] adj;
    logic          skip;

    always_comb begin
        unique case (r_radix)
            RAD_BIN: begin
                top_dig = {3'b000, r_dig[DW-1]};
                shifted = {r_dig[DW-2:0], 1'b0};
            end
            RAD_OCT: begin
                top_dig = {1'b0, r_dig[DW-1 -: 3]};
                shifted = {r_dig[DW-4:0], 3'b000};
            end
            default: begin
                top_dig = r_dig[DW-1 -: 4];
                shifted = {r_dig[DW-5:0], 4'b0000};
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NNIB; i++) begin
            adj[i*4 +: 4] = (r_dig[i*4 +: 4] >= 4'd5) ? r_dig[i*4 +: 4] + 4'd3
                                                      : r_dig[i*4 +: 4];
        end
    end

    // leading zeros are dropped, but the last digit always prints
    assign skip = (r_state == C_DIG) && !r_started && (top_dig == 4'd0)
               && (r_cnt != CW'(1));

    assign o_stat.dig_valid = (r_state == C_DIG) && !skip;
    assign o_stat.dig_last  = (r_cnt == CW'(1));
    assign o_stat.dig_char  = digit_char(top_dig, r_upper);

    always_comb begin
        n_state   = r_state;
        n_dig     = r_dig;
        n_bin     = r_bin;
        n_cnt     = r_cnt;
        n_radix   = r_radix;
        n_upper   = r_upper;
        n_started = r_started;
        unique case (r_state)
            C_IDLE: begin
                if (i_cmd.load) begin
                    n_radix   = i_cmd.radix;
                    n_upper   = i_cmd.upper;
                    n_started = 1'b0;
                    unique case (i_cmd.radix)
                        RAD_DEC: begin
                            n_dig   = '0;
                            n_bin   = i_value;
                            n_cnt   = CW'(ARG_WIDTH);
                            n_state = C_DAB;
                        end
                        RAD_BIN: begin
                            n_dig   = DW'(i_value);
                            n_cnt   = CW'(DW);
                            n_state = C_DIG;
                        end
                        RAD_OCT: begin
                            n_dig   = DW'(i_value);
                            n_cnt   = CW'(DW / 3);
                            n_state = C_DIG;
                        end
                        default: begin
                            n_dig   = DW'(i_value);
                            n_cnt   = CW'(DW / 4);
                            n_state = C_DIG;
                        end
                    endcase
                end
            end
            C_DAB: begin
                n_dig = {adj[DW-2:0], r_bin[ARG_WIDTH-1]};
                n_bin = {r_bin[ARG_WIDTH-2:0], 1'b0};
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(DW / 4);
                    n_state = C_DIG;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            C_DIG: begin
                if (skip) begin
                    n_dig = shifted;
                    n_cnt = r_cnt - CW'(1);
                end else if (i_take) begin
                    n_dig     = shifted;
                    n_cnt     = r_cnt - CW'(1);
                    n_started = 1'b1;
                    if (r_cnt == CW'(1)) begin
                        n_state = C_IDLE;
                    end
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dig     <= n_dig;
        r_bin     <= n_bin;
        r_cnt     <= n_cnt;
        r_radix   <= n_radix;
        r_upper   <= n_upper;
        r_started <= n_started;
    end

endmodule

// File: design/format_string_expander.sv
// A request is registered on acceptance and decoded in S_DECODE; its result is registered in
// the output register once the output slot is free. A new request is taken only in S_IDLE,
// after the last one is through. Text escapes step through the text table one character at
// a time; %b %o %x walk the digit slots of the converter register (48 binary, 16 octal, 12 hex
// at the default width), %d %u run ARG_WIDTH shift-add-3 steps first; a stall holds the output.
// Reset (synchronous, active low) clears parse mode, octal value, count, halt and output valid.
module format_string_expander #(
    parameter int ARG_WIDTH = fse_pkg::ARG_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  fse_pkg::t_item i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output fse_pkg::t_res  o_out_data
);
    import fse_pkg::*;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_QUO  = 8'h22;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_LT   = 8'h74;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_LN   = 8'h6E;
    localparam logic [7:0] CH_LR   = 8'h72;
    localparam logic [7:0] CH_UT   = 8'h54;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_UN   = 8'h4E;
    localparam logic [7:0] CH_UR   = 8'h52;
    localparam logic [7:0] CH_LC   = 8'h63;
    localparam logic [7:0] CH_UC   = 8'h43;
    localparam logic [7:0] CH_LD   = 8'h64;
    localparam logic [7:0] CH_LU   = 8'h75;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LO   = 8'h6F;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_TEXT   = 4'b0100,
        S_CONV   = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_char;
    logic [31:0] r_arg;
    t_mode       r_mode, n_mode;
    logic [7:0]  r_accum, n_accum;
    logic [15:0] r_count, n_count;
    logic        r_halted, n_halted;
    logic [5:0]  r_tidx, n_tidx;
    logic [5:0]  r_tend, n_tend;
    logic        r_out_valid;
    t_res        r_out;

    logic                 in_acc;
    logic                 can_emit;
    logic                 want;
    logic                 fire;
    t_res                 n_res;
    logic [63:0]          arg64;
    logic [ARG_WIDTH-1:0] argv;
    logic [ARG_WIDTH-1:0] conv_value;
    logic                 is_oct;
    logic                 is_dec;
    logic [7:0]           acc_next;
    t_conv_cmd            conv_cmd;
    t_conv_stat           conv_stat;
    logic                 conv_take;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign can_emit    = !r_out_valid || !i_out_stall;
    assign fire        = want && can_emit;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign arg64    = {32'h0, r_arg};
    assign argv     = arg64[ARG_WIDTH-1:0];
    assign is_oct   = (r_char >= 8'h30) && (r_char <= 8'h37);
    assign is_dec   = (r_char >= 8'h30) && (r_char <= 8'h39);
    assign acc_next = {r_accum[4:0], r_char[2:0]};
    assign conv_take = (r_state == S_CONV) && fire;

    fse_conv #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (conv_cmd),
        .i_value (conv_value),
        .i_take  (conv_take),
        .o_stat  (conv_stat)
    );

    always_comb begin
        logic   d_load;
        t_radix d_radix;
        logic   d_upper;
        logic   go;

        n_state    = r_state;
        n_mode     = r_mode;
        n_accum    = r_accum;
        n_halted   = r_halted;
        n_tidx     = r_tidx;
        n_tend     = r_tend;
        n_res      = '0;
        want       = 1'b0;
        d_load     = 1'b0;
        d_radix    = RAD_DEC;
        d_upper    = 1'b0;
        conv_value = argv;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !r_halted) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (r_char == CH_NUL) begin
                    want              = 1'b1;
                    n_res.done_res    = 1'b1;
                    n_res.total_count = r_count;
                    n_res.is_last     = 1'b1;
                    n_mode            = MODE_PLAIN;
                    n_accum           = 8'h00;
                end else begin
                    unique case (r_mode)
                        MODE_PLAIN: begin
                            if (r_char == CH_BSL) begin
                                n_mode = MODE_ESC;
                            end else if (r_char == CH_PCT) begin
                                n_mode = MODE_PCT;
                            end else begin
                                want           = 1'b1;
                                n_res.out_char = r_char;
                                n_res.is_last  = 1'b1;
                            end
                        end
                        MODE_ESC: begin
                            n_mode        = MODE_PLAIN;
                            want          = 1'b1;
                            n_res.is_last = 1'b1;
                            unique case (r_char)
                                CH_BSL: n_res.out_char = CH_BSL;
                                CH_QUO: n_res.out_char = CH_QUO;
                                CH_LT:  n_res.out_char = CH_TAB;
                                CH_LF:  n_res.out_char = CH_FF;
                                CH_LN:  n_res.out_char = CH_NL;
                                CH_LR:  n_res.out_char = CH_CR;
                                CH_UT: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_TAB_START;
                                    n_tend  = TXT_TAB_END;
                                    n_state = S_TEXT;
                                end
                                CH_UF: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_FF_START;
                                    n_tend  = TXT_FF_END;
                                    n_state = S_TEXT;
                                end
                                CH_UN: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_NL_START;
                                    n_tend  = TXT_NL_END;
                                    n_state = S_TEXT;
                                end
                                CH_UR: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_CR_START;
                                    n_tend  = TXT_CR_END;
                                    n_state = S_TEXT;
                                end
                                CH_LC: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_BANNER_START;
                                    n_tend  = TXT_BANNER_END;
                                    n_state = S_TEXT;
                                end
                                CH_UC: begin
                                    want    = 1'b0;
                                    n_tidx  = TXT_MAGIC_START;
                                    n_tend  = TXT_BANNER_END;
                                    n_state = S_TEXT;
                                end
                                default: begin
                                    if (is_oct) begin
                                        want    = 1'b0;
                                        n_accum = {5'b00000, r_char[2:0]};
                                        n_mode  = MODE_OCT2;
                                    end else begin
                                        n_res.error_code = ERR_ESC;
                                        n_halted         = 1'b1;
                                    end
                                end
                            endcase
                        end
                        MODE_OCT2: begin
                            if (is_oct) begin
                                n_accum = acc_next;
                                n_mode  = MODE_OCT3;
                            end else begin
                                want             = 1'b1;
                                n_res.is_last    = 1'b1;
                                n_res.error_code = ERR_OCT2;
                                n_halted         = 1'b1;
                            end
                        end
                        MODE_OCT3: begin
                            want          = 1'b1;
                            n_res.is_last = 1'b1;
                            if (is_oct) begin
                                n_accum        = acc_next;
                                n_res.out_char = acc_next;
                                n_mode         = MODE_PLAIN;
                            end else begin
                                n_res.error_code = ERR_OCT3;
                                n_halted         = 1'b1;
                            end
                        end
                        MODE_PCT: begin
                            n_mode = MODE_PLAIN;
                            unique case (r_char)
                                CH_PCT: begin
                                    want           = 1'b1;
                                    n_res.out_char = CH_PCT;
                                    n_res.is_last  = 1'b1;
                                end
                                CH_LC: begin
                                    want           = 1'b1;
                                    n_res.out_char = argv[7:0];
                                    n_res.is_last  = 1'b1;
                                end
                                CH_LD: begin
                                    d_load  = 1'b1;
                                    n_state = S_CONV;
                                    if (argv[ARG_WIDTH-1]) begin
                                        // sign goes out now, magnitude to the converter
                                        want           = 1'b1;
                                        n_res.out_char = CH_DASH;
                                        conv_value     = ~argv + 1'b1;
                                    end
                                end
                                CH_LU: begin
                                    d_load  = 1'b1;
                                    n_state = S_CONV;
                                end
                                CH_LB: begin
                                    d_load  = 1'b1;
                                    d_radix = RAD_BIN;
                                    n_state = S_CONV;
                                end
                                CH_LO: begin
                                    d_load  = 1'b1;
                                    d_radix = RAD_OCT;
                                    n_state = S_CONV;
                                end
                                CH_LX: begin
                                    d_load  = 1'b1;
                                    d_radix = RAD_HEX;
                                    n_state = S_CONV;
                                end
                                CH_UX: begin
                                    d_load  = 1'b1;
                                    d_radix = RAD_HEX;
                                    d_upper = 1'b1;
                                    n_state = S_CONV;
                                end
                                default: begin
                                    if (r_char == CH_DASH || is_dec) begin
                                        n_mode = MODE_PCT;
                                    end else begin
                                        want             = 1'b1;
                                        n_res.is_last    = 1'b1;
                                        n_res.error_code = ERR_FMT;
                                        n_halted         = 1'b1;
                                    end
                                end
                            endcase
                        end
                        default: n_mode = MODE_PLAIN;
                    endcase
                end
                // hold everything until the output slot frees up
                go = !want || can_emit;
                if (!go) begin
                    n_state  = r_state;
                    n_mode   = r_mode;
                    n_accum  = r_accum;
                    n_halted = r_halted;
                    n_tidx   = r_tidx;
                    n_tend   = r_tend;
                    d_load   = 1'b0;
                end
            end
            S_TEXT: begin
                want           = 1'b1;
                n_res.out_char = TEXT_ROM[r_tidx];
                n_res.is_last  = (r_tidx == r_tend);
                if (can_emit) begin
                    if (r_tidx == r_tend) begin
                        n_state = S_IDLE;
                    end else begin
                        n_tidx = r_tidx + 6'd1;
                    end
                end
            end
            S_CONV: begin
                want           = conv_stat.dig_valid;
                n_res.out_char = conv_stat.dig_char;
                n_res.is_last  = conv_stat.dig_last;
                if (fire && conv_stat.dig_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        conv_cmd.load  = d_load;
        conv_cmd.radix = d_radix;
        conv_cmd.upper = d_upper;
    end

    always_comb begin
        n_count = r_count;
        if (fire) begin
            if (n_res.done_res) begin
                n_count = 16'h0000;
            end else if (n_res.error_code == ERR_NONE && r_count != 16'hFFFF) begin
                n_count = r_count + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_PLAIN;
            r_accum     <= 8'h00;
            r_count     <= 16'h0000;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_accum  <= n_accum;
            r_count  <= n_count;
            r_halted <= n_halted;
            if (can_emit) begin
                r_out_valid <= want;
            end
        end
        if (in_acc) begin
            r_char <= i_in_data.fmt_char;
            r_arg  <= i_in_data.arg_value;
        end
        if (fire) begin
            r_out <= n_res;
        end
        r_tidx <= n_tidx;
        r_tend <= n_tend;
    end

endmodule

// File: verif/format_string_expander_tb.sv
// Self-checking testbench for the format string expander: directed and random strings.
`timescale 1ns / 100ps

module format_string_expander_tb;
    import fse_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT = 64;
    localparam int RANDOM_REQS = 310;
    localparam int MAX_PRINTS = 40;

    localparam logic [7:0] BANNER_TXT [10] = '{
        8'h43, 8'h41, 8'h53, 8'h50, 8'h4C, 8'h27, 8'h32, 8'h30, 8'h31, 8'h38
    };
    localparam logic [7:0] MAGIC_TXT [13] = '{
        8'h3C, 8'h63, 8'h61, 8'h73, 8'h70, 8'h6C, 8'h20, 8'h6D, 8'h61, 8'h67, 8'h69,
        8'h63, 8'h3E
    };
    localparam logic [7:0] ESC_LETTERS [12] = '{
        "t", "f", "n", "r", "\\", "\"", "T", "F", "N", "R", "c", "C"
    };
    localparam logic [7:0] SPEC_LETTERS [8] = '{"%", "c", "d", "u", "b", "o", "x", "X"};

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_stall;
    t_item in_data = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    t_res  out_data;

    // model state
    t_mode       cur_mode;
    logic [7:0]  oct_acc;
    logic [15:0] char_count;
    bit          halted;
    t_res        expected_chars [$];

    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    int unsigned mismatch_count = 0;
    int unsigned req_count = 0;
    int unsigned res_count = 0;
    int unsigned string_count = 0;
    int unsigned quiet_cycles = 0;
    logic [2:0]  err_tested = ERR_NONE;

    format_string_expander u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- expansion model ----------------

    function automatic bit is_octal(logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic void push_res(logic [7:0] ch, logic done, logic [15:0] cnt,
                                     logic [2:0] err);
        t_res r;
        r = '0;
        r.out_char = ch;
        r.done_res = done;
        r.total_count = cnt;
        r.error_code = err;
        expected_chars.push_back(r);
    endfunction

    function automatic void emit_char(logic [7:0] ch);
        push_res(ch, 1'b0, 16'd0, ERR_NONE);
        if (char_count != 16'hFFFF) begin
            char_count++;
        end
    endfunction

    function automatic void emit_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            emit_char(s[i]);
        end
    endfunction

    function automatic void emit_banner();
        foreach (BANNER_TXT[i]) begin
            emit_char(BANNER_TXT[i]);
        end
    endfunction

    function automatic void emit_number(logic [31:0] v, int unsigned radix, bit upper);
        logic [7:0]  digs [32];
        logic [31:0] d;
        int          n;
        n = 0;
        do begin
            d = v % radix;
            if (d < 10) begin
                digs[n] = 8'h30 + d[7:0];
            end else begin
                digs[n] = (upper ? 8'h41 : 8'h61) + d[7:0] - 8'd10;
            end
            n++;
            v = v / radix;
        end while (v != 0);
        while (n > 0) begin
            n--;
            emit_char(digs[n]);
        end
    endfunction

    function automatic void raise_error(logic [2:0] code);
        push_res(8'h00, 1'b0, 16'd0, code);
        halted = 1'b1;
    endfunction

    function automatic void handle_escape(logic [7:0] c);
        cur_mode = MODE_PLAIN;
        case (c)
            "\\", "\"": emit_char(c);
            "t": emit_char(8'h09);
            "f": emit_char(8'h0C);
            "n": emit_char(8'h0A);
            "r": emit_char(8'h0D);
            "T": begin
                emit_str("<tab>");
                emit_char(8'h09);
            end
            "F": begin
                emit_str("<formfeed>");
                emit_char(8'h0C);
            end
            "N": begin
                emit_str("<newline>");
                emit_char(8'h0A);
            end
            "R": begin
                emit_str("<return>");
                emit_char(8'h0D);
            end
            "c": emit_banner();
            "C": begin
                foreach (MAGIC_TXT[i]) begin
                    emit_char(MAGIC_TXT[i]);
                end
                emit_banner();
            end
            default: begin
                if (is_octal(c)) begin
                    oct_acc = c - "0";
                    cur_mode = MODE_OCT2;
                end else begin
                    raise_error(ERR_ESC);
                end
            end
        endcase
    endfunction

    function automatic void handle_spec(logic [7:0] c, logic [31:0] a);
        logic [31:0] v;
        v = a;
        cur_mode = MODE_PLAIN;
        case (c)
            "%": emit_char(c);
            "c": emit_char(v[7:0]);
            "d": begin
                if (v[31]) begin
                    emit_char("-");
                    v = ~v + 32'd1;
                end
                emit_number(v, 10, 1'b0);
            end
            "u": emit_number(v, 10, 1'b0);
            "b": emit_number(v, 2, 1'b0);
            "o": emit_number(v, 8, 1'b0);
            "x": emit_number(v, 16, 1'b0);
            "X": emit_number(v, 16, 1'b1);
            default: begin
                // width digits and '-' are swallowed
                if (c == "-" || (c >= "0" && c <= "9")) begin
                    cur_mode = MODE_PCT;
                end else begin
                    raise_error(ERR_FMT);
                end
            end
        endcase
    endfunction

    function automatic void expand_char(t_item it);
        logic [7:0]  c;
        int unsigned n_before;
        t_res        r;
        c = it.fmt_char;
        n_before = expected_chars.size();
        if (halted) begin
            return;
        end
        if (c == 8'h00) begin
            push_res(8'h00, 1'b1, char_count, ERR_NONE);
            cur_mode = MODE_PLAIN;
            oct_acc = '0;
            char_count = '0;
        end else begin
            case (cur_mode)
                MODE_PLAIN: begin
                    if (c == "\\") begin
                        cur_mode = MODE_ESC;
                    end else if (c == "%") begin
                        cur_mode = MODE_PCT;
                    end else begin
                        emit_char(c);
                    end
                end
                MODE_ESC: handle_escape(c);
                MODE_OCT2: begin
                    if (is_octal(c)) begin
                        oct_acc = {oct_acc[4:0], 3'b000} + (c - "0");
                        cur_mode = MODE_OCT3;
                    end else begin
                        raise_error(ERR_OCT2);
                    end
                end
                MODE_OCT3: begin
                    if (is_octal(c)) begin
                        oct_acc = {oct_acc[4:0], 3'b000} + (c - "0");
                        emit_char(oct_acc);
                        cur_mode = MODE_PLAIN;
                    end else begin
                        raise_error(ERR_OCT3);
                    end
                end
                MODE_PCT: handle_spec(c, it.arg_value);
                default: cur_mode = MODE_PLAIN;
            endcase
        end
        if (expected_chars.size() > n_before) begin
            r = expected_chars.pop_back();
            r.is_last = 1'b1;
            expected_chars.push_back(r);
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("%0t: %s differs: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    always @(posedge clk) begin
        t_res want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (out_valid && !out_stall) begin
                res_count++;
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected result", 32'(out_data), 32'd0);
                end else begin
                    want = expected_chars.pop_front();
                    if (out_data.out_char != want.out_char)
                        report_mismatch("out_char", 32'(out_data.out_char),
                                        32'(want.out_char));
                    if (out_data.is_last != want.is_last)
                        report_mismatch("is_last", 32'(out_data.is_last),
                                        32'(want.is_last));
                    if (out_data.done_res != want.done_res)
                        report_mismatch("done_res", 32'(out_data.done_res),
                                        32'(want.done_res));
                    if (out_data.total_count != want.total_count)
                        report_mismatch("total_count", 32'(out_data.total_count),
                                        32'(want.total_count));
                    if (out_data.error_code != want.error_code)
                        report_mismatch("error_code", 32'(out_data.error_code),
                                        32'(want.error_code));
                end
            end
        end
    end

    always @(negedge clk) begin
        out_stall <= stall_on && ($urandom_range(99) < 28);
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ---------------- stimulus ----------------

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(logic [7:0] ch, logic [31:0] arg);
        t_item it;
        it.fmt_char = ch;
        it.arg_value = arg;
        if (idle_on && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expand_char(it);
        req_count++;
        if (ch == 8'h00) begin
            string_count++;
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (expected_chars.size() != 0);
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == "\\" || c == "%");
        return c;
    endfunction

    function automatic logic [7:0] pick_flag();
        return ($urandom_range(0, 3) == 0) ? "-" : 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_oct();
        return 8'("0" + $urandom_range(0, 7));
    endfunction

    task automatic send_escape(logic [7:0] letter);
        send_request("\\", $urandom);
        send_request(letter, $urandom);
    endtask

    task automatic send_octal(logic [7:0] d0, logic [7:0] d1, logic [7:0] d2);
        send_request("\\", $urandom);
        send_request(d0, $urandom);
        send_request(d1, $urandom);
        send_request(d2, $urandom);
    endtask

    task automatic send_spec(logic [7:0] letter, logic [31:0] arg, int n_flags);
        send_request("%", $urandom);
        repeat (n_flags) send_request(pick_flag(), $urandom);
        send_request(letter, arg);
    endtask

    task automatic test_plain_bytes();
        send_request(8'h01, 32'h0);
        send_request(8'hFF, 32'hFFFF_FFFF);
        send_request(8'h00, 32'h0);
        send_request(8'h00, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_escapes();
        send_escape("C");
        send_escape("T");
        send_octal("7", "7", "7");
        // terminator right after a backslash
        send_request("\\", 32'h0);
        send_request(8'h00, 32'h0);
        wait_drained();
    endtask

    task automatic test_specifiers();
        send_spec("d", 32'h8000_0000, 0);
        send_spec("X", 32'hDEAD_BEEF, 1);
        send_spec("b", 32'hFFFF_FFFF, 0);
        send_spec("c", 32'h0000_01FF, 0);
        send_spec("u", 32'h0, 0);
        send_request("%", 32'h0);
        send_request(8'h00, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_strings();
        int unsigned n;
        int unsigned base;
        bit          paused;
        paused = 1'b0;
        base = req_count;
        n = 0;
        while (n < RANDOM_REQS) begin
            idle_on = !(n >= 120 && n < 220);
            stall_on = idle_on;
            if (!paused && n >= 260) begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: send_request(pick_plain(), $urandom);
                6, 7, 8: send_escape(ESC_LETTERS[$urandom_range(0, 11)]);
                9, 10: send_octal(pick_oct(), pick_oct(), pick_oct());
                11, 12, 13, 14, 15: send_spec(SPEC_LETTERS[$urandom_range(0, 7)], pick_arg(),
                                              $urandom_range(0, 2));
                16, 17: send_request(8'h00, $urandom);
                default: begin
                    // string cut off in the middle of an escape or specifier
                    case ($urandom_range(0, 3))
                        0: send_request("\\", $urandom);
                        1: send_request("%", $urandom);
                        2: begin
                            send_request("\\", $urandom);
                            send_request(pick_oct(), $urandom);
                        end
                        default: begin
                            send_request("\\", $urandom);
                            send_request(pick_oct(), $urandom);
                            send_request(pick_oct(), $urandom);
                        end
                    endcase
                    send_request(8'h00, $urandom);
                end
            endcase
            n = req_count - base;
        end
        idle_on = 1'b1;
        stall_on = 1'b1;
        send_request(8'h00, $urandom);
        wait_drained();
    endtask

    task automatic test_error_halt();
        logic [7:0] c;
        err_tested = 3'($urandom_range(ERR_ESC, ERR_FMT));
        send_request("x", $urandom);
        case (err_tested)
            ERR_ESC: begin
                do c = 8'($urandom_range(1, 255));
                while (is_octal(c) || c inside {ESC_LETTERS});
                send_escape(c);
            end
            ERR_OCT2: begin
                do c = 8'($urandom_range(1, 255)); while (is_octal(c));
                send_octal("3", c, "1");
            end
            ERR_OCT3: begin
                do c = 8'($urandom_range(1, 255)); while (is_octal(c));
                send_octal("3", "4", c);
            end
            default: begin
                do c = 8'($urandom_range(1, 255));
                while (c == "-" || (c >= "0" && c <= "9") || c inside {SPEC_LETTERS});
                send_spec(c, $urandom, $urandom_range(0, 1));
            end
        endcase
        // halted: nothing more may come out
        send_request("z", $urandom);
        send_spec("d", 32'd42, 0);
        send_escape("C");
        send_request(8'h00, $urandom);
        wait_drained();
    endtask

    initial begin
        cur_mode = MODE_PLAIN;
        oct_acc = '0;
        char_count = '0;
        halted = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_plain_bytes();
        test_escapes();
        test_specifiers();
        test_random_strings();
        test_error_halt();

        repeat (END_WAIT) @(negedge clk);
        $display("Ran %0d requests over %0d strings, %0d results checked", req_count,
                 string_count, res_count);
        $display("Covered escapes, octal, all specifiers and a halt after error code %0d",
                 err_tested);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: format_string_expander.f
design/fse_pkg.sv
design/fse_conv.sv
design/format_string_expander.sv
verif/format_string_expander_tb.sv
